FILE: hw/rtl/desmq_pkg.sv
// Shared types and constants for the directed edge store.
// No dependencies; used by directed_edge_store_mutual_query and the bench.
`timescale 1ns / 1ps

package desmq_pkg;

  // Node numbers are fixed at 6 bits, so at most 64 rows are addressable
  localparam int NODE_W        = 6;
  localparam int MAX_ROWS      = 64;
  localparam int NODES_DEFAULT = 64;

  typedef enum logic [1:0] {
    OP_ADD         = 2'd0,
    OP_REMOVE      = 2'd1,
    OP_LIST_OUT    = 2'd2,
    OP_LIST_MUTUAL = 2'd3
  } op_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_MISSING = 1'b1;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] neighbor;
    logic              has_node;
    logic              last;
    logic              status;
  } rsp_t;

endpackage

FILE: hw/rtl/desmq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module desmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we; register read data only on re so it holds otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/directed_edge_store_mutual_query.sv
// Directed graph store: adjacency rows plus a transposed copy for mutual queries.
// Depends on desmq_pkg and desmq_ram.
//
//   Channel | Handshake            | Payload           | Moves
//   --------+----------------------+-------------------+---------------------------
//   request | req_valid, req_ready | req (req_t)       | op, from_node, to_node
//   result  | rsp_valid, rsp_ready | rsp (rsp_t)       | neighbor, has_node, last, status
//
// Add and remove do one memory read after acceptance, then one write-back.
// A list does one memory read, then scans the row bit-serially, one bit per cycle
// while the result register is free, stopping after the last set bit.
// Reset clears a valid bit per row in each memory; an invalid row reads as no edges,
// so no clearing pass is needed. One request is in flight at a time.
// A stalled result holds in the output register; the scan waits while it is full.
`timescale 1ns / 1ps

module directed_edge_store_mutual_query #(
  parameter int NODES = desmq_pkg::NODES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  desmq_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output desmq_pkg::rsp_t   rsp
);

  localparam int ROWS = (NODES < desmq_pkg::MAX_ROWS) ? NODES : desmq_pkg::MAX_ROWS;
  localparam int AW   = $clog2(ROWS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t                       state;
  desmq_pkg::op_t               op_q;
  logic [desmq_pkg::NODE_W-1:0] a_q;
  logic [desmq_pkg::NODE_W-1:0] b_q;
  logic [ROWS-1:0]              row_valid;
  logic [ROWS-1:0]              col_valid;
  logic [ROWS-1:0]              scan;
  logic [desmq_pkg::NODE_W-1:0] idx;

  logic                         accept;
  logic                         go;
  logic                         is_list;
  logic [AW-1:0]                col_raddr;
  logic [ROWS-1:0]              row_rdata;
  logic [ROWS-1:0]              col_rdata;
  logic                         row_we;
  logic                         col_we;
  logic [ROWS-1:0]              row_wdata;
  logic [ROWS-1:0]              col_wdata;
  logic [desmq_pkg::NODE_W-1:0] c_node;
  logic [AW-1:0]                a_idx;
  logic [AW-1:0]                c_idx;
  logic                         a_ok;
  logic                         b_ok;
  logic                         c_ok;
  logic [ROWS-1:0]              amask;
  logic [ROWS-1:0]              bmask;
  logic [ROWS-1:0]              row_cur;
  logic [ROWS-1:0]              col_cur;
  logic                         present;
  logic [ROWS-1:0]              hits;
  logic                         scan_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign go        = !rsp_valid || rsp_ready;

  // Read row of from_node; transposed row of to_node for edits, from_node for lists
  assign col_raddr = (req.op == desmq_pkg::OP_ADD || req.op == desmq_pkg::OP_REMOVE)
                     ? req.to_node[AW-1:0] : req.from_node[AW-1:0];

  desmq_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (a_idx),
    .wdata (row_wdata),
    .re    (accept),
    .raddr (req.from_node[AW-1:0]),
    .rdata (row_rdata)
  );

  desmq_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (c_idx),
    .wdata (col_wdata),
    .re    (accept),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // Decode the held request against the read data
  always_comb begin
    is_list = (op_q == desmq_pkg::OP_LIST_OUT) || (op_q == desmq_pkg::OP_LIST_MUTUAL);
    c_node  = is_list ? a_q : b_q;
    a_idx   = a_q[AW-1:0];
    c_idx   = c_node[AW-1:0];
    a_ok    = 32'(a_q) < ROWS;
    b_ok    = 32'(b_q) < ROWS;
    c_ok    = 32'(c_node) < ROWS;
    amask   = {{(ROWS-1){1'b0}}, 1'b1} << a_q;
    bmask   = {{(ROWS-1){1'b0}}, 1'b1} << b_q;
    row_cur = (a_ok && row_valid[a_idx]) ? row_rdata : '0;
    col_cur = (c_ok && col_valid[c_idx]) ? col_rdata : '0;
    present = |(row_cur & bmask);
    hits    = (op_q == desmq_pkg::OP_LIST_MUTUAL) ? (row_cur & col_cur) : row_cur;

    row_we    = 1'b0;
    col_we    = 1'b0;
    row_wdata = row_cur | bmask;
    col_wdata = col_cur | amask;
    if (state == S_EXEC && go) begin
      case (op_q)
        desmq_pkg::OP_ADD: begin
          row_we = a_ok && b_ok;
          col_we = a_ok && b_ok;
        end
        desmq_pkg::OP_REMOVE: begin
          row_wdata = row_cur & ~bmask;
          col_wdata = col_cur & ~amask;
          row_we    = present;
          col_we    = present;
        end
        default: begin
          row_we = 1'b0;
          col_we = 1'b0;
        end
      endcase
    end

    scan_last = ~|scan[ROWS-1:1];
  end

  // Sequence the request, hold valid bits and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      row_valid <= '0;
      col_valid <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (row_we) begin
        row_valid[a_idx] <= 1'b1;
      end
      if (col_we) begin
        col_valid[c_idx] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.op;
            a_q   <= req.from_node;
            b_q   <= req.to_node;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            if (!is_list || hits == '0) begin
              // Single result: edit acknowledge or empty list
              rsp_valid    <= 1'b1;
              rsp.neighbor <= '0;
              rsp.has_node <= 1'b0;
              rsp.last     <= 1'b1;
              rsp.status   <= (op_q == desmq_pkg::OP_REMOVE && !present)
                              ? desmq_pkg::STATUS_MISSING : desmq_pkg::STATUS_OK;
              state        <= S_IDLE;
            end else begin
              scan  <= hits;
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (go) begin
            // Emit on a set bit, then advance one column
            if (scan[0]) begin
              rsp_valid    <= 1'b1;
              rsp.neighbor <= idx;
              rsp.has_node <= 1'b1;
              rsp.last     <= scan_last;
              rsp.status   <= desmq_pkg::STATUS_OK;
              if (scan_last) begin
                state <= S_IDLE;
              end
            end
            scan <= scan >> 1;
            idx  <= idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Reset leaves every row reading as empty
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (row_valid == '0 && col_valid == '0))
    else $error("valid bits not cleared by reset");

  // Only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("request accepted while another is in flight");

  // Row and transposed copy are written together, only when the result slot is free
  a_paired_write: assert property (@(posedge clk) disable iff (rst)
    (row_we || col_we) |-> (row_we && col_we && state == S_EXEC && go))
    else $error("unpaired or unscheduled memory write");

  // A listed node never carries an error status
  a_node_ok_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.has_node) |-> (rsp.status == desmq_pkg::STATUS_OK))
    else $error("listed node with error status");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the directed edge store: add, remove, out-list and mutual-list requests.
// Depends on desmq_pkg and directed_edge_store_mutual_query; keeps its own copy of the edge matrix.
`timescale 1ns / 1ps

module tb_top;

  localparam int GRAPH_NODES  = desmq_pkg::NODES_DEFAULT;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 2 * desmq_pkg::MAX_ROWS;
  localparam int TIMEOUT_NS   = 20_000_000;
  localparam int PRINT_CAP    = 50;

  localparam desmq_pkg::rsp_t DONE_OK      = '{neighbor: '0, has_node: 1'b0, last: 1'b1,
                                               status: desmq_pkg::STATUS_OK};
  localparam desmq_pkg::rsp_t DONE_MISSING = '{neighbor: '0, has_node: 1'b0, last: 1'b1,
                                               status: desmq_pkg::STATUS_MISSING};
  localparam desmq_pkg::rsp_t EMPTY_LIST   = DONE_OK;
  localparam desmq_pkg::rsp_t NO_PIN       = '0;

  typedef struct packed {
    desmq_pkg::op_t                         op;
    logic [desmq_pkg::NODE_W-1:0]           from_node;
    logic [desmq_pkg::NODE_W-1:0]           to_node;
    logic                                   pinned;
    desmq_pkg::rsp_t                        want;
  } stim_row_t;

  // Directed requests; pinned rows carry a result that is obvious at a glance
  localparam int N_DIRECTED = 21;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{desmq_pkg::OP_LIST_OUT,    6'd0,  6'd0,  1'b1, EMPTY_LIST},    // empty graph after reset
    '{desmq_pkg::OP_LIST_MUTUAL, 6'd63, 6'd0,  1'b1, EMPTY_LIST},
    '{desmq_pkg::OP_REMOVE,      6'd0,  6'd0,  1'b1, DONE_MISSING},  // remove of an absent edge
    '{desmq_pkg::OP_REMOVE,      6'd63, 6'd63, 1'b1, DONE_MISSING},
    '{desmq_pkg::OP_ADD,         6'd0,  6'd0,  1'b1, DONE_OK},       // self loop
    '{desmq_pkg::OP_ADD,         6'd0,  6'd0,  1'b1, DONE_OK},       // duplicate add
    '{desmq_pkg::OP_ADD,         6'd0,  6'd63, 1'b1, DONE_OK},
    '{desmq_pkg::OP_ADD,         6'd63, 6'd0,  1'b1, DONE_OK},
    '{desmq_pkg::OP_ADD,         6'd0,  6'd42, 1'b1, DONE_OK},
    '{desmq_pkg::OP_ADD,         6'd63, 6'd63, 1'b1, DONE_OK},
    '{desmq_pkg::OP_LIST_OUT,    6'd0,  6'd0,  1'b0, NO_PIN},
    '{desmq_pkg::OP_LIST_MUTUAL, 6'd0,  6'd0,  1'b0, NO_PIN},
    '{desmq_pkg::OP_LIST_MUTUAL, 6'd63, 6'd42, 1'b0, NO_PIN},
    '{desmq_pkg::OP_LIST_OUT,    6'd42, 6'd0,  1'b1, EMPTY_LIST},    // node with in-edges only
    '{desmq_pkg::OP_ADD,         6'd21, 6'd42, 1'b1, DONE_OK},
    '{desmq_pkg::OP_ADD,         6'd42, 6'd21, 1'b1, DONE_OK},
    '{desmq_pkg::OP_LIST_MUTUAL, 6'd21, 6'd63, 1'b0, NO_PIN},        // to_node ignored by queries
    '{desmq_pkg::OP_REMOVE,      6'd0,  6'd42, 1'b1, DONE_OK},
    '{desmq_pkg::OP_REMOVE,      6'd0,  6'd42, 1'b1, DONE_MISSING},  // second remove finds nothing
    '{desmq_pkg::OP_LIST_OUT,    6'd0,  6'd21, 1'b0, NO_PIN},
    '{desmq_pkg::OP_LIST_MUTUAL, 6'd42, 6'd0,  1'b0, NO_PIN}
  };

  logic            clk = 1'b0;
  logic            rst;
  logic            req_valid;
  logic            req_ready;
  desmq_pkg::req_t req;
  logic            rsp_valid;
  logic            rsp_ready;
  desmq_pkg::rsp_t rsp;

  // Predictor state and result bookkeeping
  logic [desmq_pkg::MAX_ROWS-1:0] edges [desmq_pkg::MAX_ROWS];
  desmq_pkg::rsp_t graph_rsp_step [$];
  desmq_pkg::rsp_t graph_rsp_due [$];
  int   bad_fields = 0;
  logic calm = 1'b0;
  logic hold_request = 1'b0;

  directed_edge_store_mutual_query #(
    .NODES(GRAPH_NODES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  function automatic logic in_graph(input logic [desmq_pkg::NODE_W-1:0] n);
    return int'(n) < GRAPH_NODES;
  endfunction

  function automatic logic edge_set(input logic [desmq_pkg::NODE_W-1:0] r,
                                    input logic [desmq_pkg::NODE_W-1:0] c);
    return in_graph(r) && in_graph(c) && edges[r][c];
  endfunction

  // Apply one request to the edge matrix and list the results it causes
  function automatic void graph_apply(input desmq_pkg::req_t r);
    desmq_pkg::rsp_t o;
    logic [desmq_pkg::NODE_W-1:0] c;
    graph_rsp_step.delete();
    o = DONE_OK;
    case (r.op)
      desmq_pkg::OP_ADD: begin
        if (in_graph(r.from_node) && in_graph(r.to_node)) edges[r.from_node][r.to_node] = 1'b1;
        graph_rsp_step.push_back(o);
      end
      desmq_pkg::OP_REMOVE: begin
        if (edge_set(r.from_node, r.to_node)) edges[r.from_node][r.to_node] = 1'b0;
        else o.status = desmq_pkg::STATUS_MISSING;
        graph_rsp_step.push_back(o);
      end
      default: begin
        // Scan the row in ascending order; mutual also needs the back edge
        for (int i = 0; i < desmq_pkg::MAX_ROWS; i++) begin
          c = desmq_pkg::NODE_W'(i);
          if (edge_set(r.from_node, c) &&
              (r.op == desmq_pkg::OP_LIST_OUT || edge_set(c, r.from_node))) begin
            o = '0;
            o.neighbor = c;
            o.has_node = 1'b1;
            o.status   = desmq_pkg::STATUS_OK;
            graph_rsp_step.push_back(o);
          end
        end
        if (graph_rsp_step.size() == 0) graph_rsp_step.push_back(EMPTY_LIST);
        else graph_rsp_step[graph_rsp_step.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  task automatic flag_field(input string msg);
    bad_fields++;
    if (bad_fields <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Mostly a small pool of nodes so edges meet again; now and then any node
  function automatic logic [desmq_pkg::NODE_W-1:0] pick_node();
    if ($urandom_range(0, 3) == 0)
      return desmq_pkg::NODE_W'($urandom_range(0, desmq_pkg::MAX_ROWS-1));
    return desmq_pkg::NODE_W'($urandom_range(0, 5) + ($urandom_range(0, 1) ? 58 : 0));
  endfunction

  function automatic desmq_pkg::req_t random_request();
    desmq_pkg::req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.op = (pick < 40) ? desmq_pkg::OP_ADD :
           (pick < 65) ? desmq_pkg::OP_REMOVE :
           (pick < 80) ? desmq_pkg::OP_LIST_OUT : desmq_pkg::OP_LIST_MUTUAL;
    r.from_node = pick_node();
    r.to_node   = pick_node();
    return r;
  endfunction

  // Offer one request, hold it until accepted, then log its results
  task automatic issue(input desmq_pkg::req_t r, input logic pinned,
                       input desmq_pkg::rsp_t want);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    graph_apply(r);
    if (pinned) graph_rsp_due.push_back(want);
    else foreach (graph_rsp_step[i]) graph_rsp_due.push_back(graph_rsp_step[i]);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Request side
  initial begin : request_side
    desmq_pkg::req_t r;
    logic [desmq_pkg::NODE_W-1:0] order [desmq_pkg::MAX_ROWS];
    logic [desmq_pkg::NODE_W-1:0] tmp;
    logic [desmq_pkg::NODE_W-1:0] hub;
    int j;
    foreach (edges[i]) edges[i] = '0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      r.op        = DIRECTED_ROWS[i].op;
      r.from_node = DIRECTED_ROWS[i].from_node;
      r.to_node   = DIRECTED_ROWS[i].to_node;
      issue(r, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
    end

    // Pause until the block has drained
    req_valid <= 1'b0;
    wait (graph_rsp_due.size() == 0);
    @(posedge clk);

    // Random mix over a small node pool
    repeat (60) issue(random_request(), 1'b0, NO_PIN);

    // Fill one row completely in random order, with some back edges, then list it
    hub = desmq_pkg::NODE_W'($urandom_range(0, desmq_pkg::MAX_ROWS-1));
    for (int i = 0; i < desmq_pkg::MAX_ROWS; i++) order[i] = desmq_pkg::NODE_W'(i);
    for (int i = desmq_pkg::MAX_ROWS-1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < desmq_pkg::MAX_ROWS; i++) begin
      issue('{op: desmq_pkg::OP_ADD, from_node: hub, to_node: order[i]}, 1'b0, NO_PIN);
      if ($urandom_range(0, 3) == 0)
        issue('{op: desmq_pkg::OP_ADD, from_node: order[i], to_node: hub}, 1'b0, NO_PIN);
    end
    // Stall the result side while full lists and more requests pile up
    hold_request = 1'b1;
    issue('{op: desmq_pkg::OP_LIST_OUT, from_node: hub, to_node: '0}, 1'b0, NO_PIN);
    issue('{op: desmq_pkg::OP_LIST_MUTUAL, from_node: hub, to_node: '1}, 1'b0, NO_PIN);

    // More random requests; the tail runs without idling
    for (int i = 0; i < 70; i++) begin
      if (i == 30) calm = 1'b1;
      issue(random_request(), 1'b0, NO_PIN);
    end
    req_valid <= 1'b0;

    wait (graph_rsp_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random ready with bursts of stall, one long hold on request
  initial begin : result_side
    logic held;
    held = 1'b0;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin : result_check
    desmq_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (graph_rsp_due.size() == 0) begin
        flag_field($sformatf("unexpected result neighbor=%0d has_node=%0b last=%0b status=%0b",
                             rsp.neighbor, rsp.has_node, rsp.last, rsp.status));
      end else begin
        want = graph_rsp_due.pop_front();
        if (rsp.neighbor !== want.neighbor)
          flag_field($sformatf("neighbor got %0d want %0d", rsp.neighbor, want.neighbor));
        if (rsp.has_node !== want.has_node)
          flag_field($sformatf("has_node got %0b want %0b", rsp.has_node, want.has_node));
        if (rsp.last !== want.last)
          flag_field($sformatf("last got %0b want %0b (neighbor %0d)",
                               rsp.last, want.last, want.neighbor));
        if (rsp.status !== want.status)
          flag_field($sformatf("status got %0b want %0b", rsp.status, want.status));
      end
    end
  end

  // Give up after a generous fixed time
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/desmq_pkg.sv
hw/rtl/desmq_ram.sv
hw/rtl/directed_edge_store_mutual_query.sv
tb/tb_top.sv
